### rtl/core/sil_pkg.sv
// Package for the sorted insertion list unit.
// Holds sizes, operation and status codes and the cell control struct.
// No dependencies.
package sil_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = 5;
  localparam int unsigned PosW  = 5;
  localparam int unsigned IdxW  = $clog2(DEPTH);

  typedef logic signed [DataW-1:0] data_t;

  localparam logic [1:0] ModeInsert = 2'd0;
  localparam logic [1:0] ModeRemove = 2'd1;
  localparam logic [1:0] ModeDump   = 2'd2;

  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatFull   = 2'd1;
  localparam logic [1:0] StatBadPos = 2'd2;
  localparam logic [1:0] StatEmpty  = 2'd3;

  typedef enum logic [1:0] {
    OpHold,
    OpInsert,
    OpRemove,
    OpRotate
  } cell_op_e;

  typedef struct packed {
    cell_op_e             op;
    data_t                value;
    logic [CntW-1:0]      occ;
    logic [PosW-1:0]      pos;
  } cell_ctl_t;

endpackage

### rtl/core/sil_if.sv
// Request and result channel interfaces of the sorted insertion list unit.
// Depends on sil_pkg.
interface sil_req_if
  import sil_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [1:0]      mode;
  data_t           value;
  logic [PosW-1:0] position;

  modport source (output valid, output mode, output value, output position, input ready);
  modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

interface sil_rsp_if
  import sil_pkg::*;
();
  logic            valid;
  logic            ready;
  data_t           element;
  logic [CntW-1:0] entries;
  logic [1:0]      status;
  logic            last;

  modport source (output valid, output element, output entries, output status, output last,
                  input ready);
  modport sink   (input valid, input element, input entries, input status, input last,
                  output ready);
endinterface

### rtl/core/sil_cell.sv
// One storage cell of the sorted list chain.
// Shifts, loads or rotates its value from its neighbors under the shared control.
// Depends on sil_pkg.
module sil_cell
  import sil_pkg::*;
(
  input  logic            clk_i,
  input  logic [IdxW-1:0] idx_i,
  input  cell_ctl_t       ctl_i,
  input  data_t           left_val_i,
  input  logic            left_after_i,
  input  data_t           right_val_i,
  input  data_t           head_val_i,
  output data_t           val_o,
  output logic            after_o
);

  data_t           val_q, val_d;
  logic [CntW-1:0] idx_ext;

  assign idx_ext = CntW'(idx_i);
  assign after_o = (val_q > ctl_i.value) || (idx_ext >= ctl_i.occ);
  assign val_o   = val_q;

  always_comb begin
    val_d = val_q;
    unique case (ctl_i.op)
      OpHold: val_d = val_q;
      OpInsert: begin
        if (after_o && left_after_i) begin
          val_d = left_val_i;
        end else if (after_o) begin
          val_d = ctl_i.value;
        end
      end
      OpRemove: begin
        if ((idx_ext + CntW'(1)) >= ctl_i.pos) begin
          val_d = right_val_i;
        end
      end
      OpRotate: begin
        if (idx_ext == ctl_i.occ - CntW'(1)) begin
          val_d = head_val_i;
        end else if (idx_ext < ctl_i.occ) begin
          val_d = right_val_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

### rtl/core/sorted_insertion_list_unit.sv
// Top level of the sorted insertion list unit: control, count and result register.
// Instantiates a chain of sil_cell; depends on sil_pkg and the sil_if interfaces.
//
//   channel  dir  payload                          role
//   req_i    in   mode, value, position            one operation per request
//   rsp_o    out  element, entries, status, last   results, last marks the end
//
// Insert, remove and error requests give one result each.
// A dump of N values first takes the request, then gives one element per cycle
// from the head cell while the chain rotates, held while the result is stalled;
// a new request waits until the cycle after the dump's last element.
// Reset clears the count, the state and the result valid; cell contents stay.
// A stalled result holds the result register and the dump rotation.
module sorted_insertion_list_unit
  import sil_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  sil_req_if.sink   req_i,
  sil_rsp_if.source rsp_o
);

  localparam logic SIdle = 1'b0;
  localparam logic SDump = 1'b1;

  logic            state_q, state_d;
  logic [CntW-1:0] occ_q, occ_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  data_t           out_elem_q, out_elem_d;
  logic [CntW-1:0] out_ent_q, out_ent_d;
  logic [1:0]      out_stat_q, out_stat_d;
  logic            out_last_q, out_last_d;

  logic            out_free, accept, dump_emit, dump_last, pos_ok;
  cell_ctl_t       ctl;
  data_t           vals [DEPTH];
  logic            afters [DEPTH];

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == SIdle) && out_free;
  assign accept      = req_i.valid && req_i.ready;
  assign dump_emit   = (state_q == SDump) && out_free;
  assign dump_last   = (CntW'(cnt_q) == occ_q - CntW'(1));
  assign pos_ok      = (req_i.position != '0) && (req_i.position <= occ_q);

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_elem_d  = out_elem_q;
    out_ent_d   = out_ent_q;
    out_stat_d  = out_stat_q;
    out_last_d  = out_last_q;
    ctl.op      = OpHold;
    ctl.value   = req_i.value;
    ctl.occ     = occ_q;
    ctl.pos     = req_i.position;

    if (accept) begin
      out_elem_d = '0;
      out_last_d = 1'b1;
      out_stat_d = StatOk;
      unique case (req_i.mode)
        ModeInsert: begin
          if (occ_q >= CntW'(DEPTH)) begin
            out_stat_d = StatFull;
          end else begin
            ctl.op = OpInsert;
            occ_d  = occ_q + CntW'(1);
          end
        end
        ModeRemove: begin
          if (pos_ok) begin
            ctl.op = OpRemove;
            occ_d  = occ_q - CntW'(1);
          end else begin
            out_stat_d = StatBadPos;
          end
        end
        ModeDump: begin
          if (occ_q == '0) begin
            out_stat_d = StatEmpty;
          end
        end
        default: out_stat_d = StatOk;
      endcase
      out_ent_d = occ_d;
      if ((req_i.mode == ModeDump) && (occ_q != '0)) begin
        state_d = SDump;
        cnt_d   = '0;
      end else begin
        out_valid_d = 1'b1;
      end
    end else if (dump_emit) begin
      ctl.op      = OpRotate;
      out_valid_d = 1'b1;
      out_elem_d  = vals[0];
      out_ent_d   = occ_q;
      out_stat_d  = StatOk;
      out_last_d  = dump_last;
      cnt_d       = cnt_q + IdxW'(1);
      if (dump_last) begin
        state_d = SIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      occ_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_elem_q <= out_elem_d;
    out_ent_q  <= out_ent_d;
    out_stat_q <= out_stat_d;
    out_last_q <= out_last_d;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sil_cell u_cell (
      .clk_i        (clk_i),
      .idx_i        (IdxW'(i)),
      .ctl_i        (ctl),
      .left_val_i   ((i == 0) ? vals[0] : vals[(i == 0) ? 0 : i - 1]),
      .left_after_i ((i == 0) ? 1'b0 : afters[(i == 0) ? 0 : i - 1]),
      .right_val_i  (vals[(i == DEPTH - 1) ? i : i + 1]),
      .head_val_i   (vals[0]),
      .val_o        (vals[i]),
      .after_o      (afters[i])
    );
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.element = out_elem_q;
  assign rsp_o.entries = out_ent_q;
  assign rsp_o.status  = out_stat_q;
  assign rsp_o.last    = out_last_q;

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntW'(DEPTH))
    else $error("occupancy above depth");

  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDump) |-> ((occ_q != '0) && (occ_d == occ_q)))
    else $error("dump with empty or changing list");

  a_dump_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dump_emit && dump_last) |=> ((state_q == SIdle) && out_valid_q && out_last_q))
    else $error("dump did not end on last element");

  a_result_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.mode != ModeDump)) |=> (out_valid_q && out_last_q))
    else $error("missing single result");
`endif

endmodule
